/* rtl/core/lsfp_pkg.sv */
package lsfp_pkg;

	localparam logic [7:0] HDR_BYTE  = 8'hFF;
	localparam logic [7:0] TAIL_BYTE = 8'hFE;
	localparam logic [3:0] FP_IDLE   = 4'd0;
	localparam logic [3:0] FP_LAST_CH = 4'd8;
	localparam logic [3:0] FP_CSUM   = 4'd9;
	localparam logic [3:0] FP_TAIL   = 4'd10;

	localparam int MAG_W     = 13;
	localparam int DIV_STEPS = MAG_W;

	typedef enum logic [1:0] {
		EV_NONE     = 2'd0,
		EV_VALID    = 2'd1,
		EV_FORMAT   = 2'd2,
		EV_CHECKSUM = 2'd3
	} ev_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_OUT  = 3'b100
	} state_t;

	// divider request: magnitude of the weighted sum, sign, detect count
	typedef struct packed {
		logic             start;
		logic             neg;
		logic [MAG_W-1:0] mag;
		logic [2:0]       den;
	} div_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [MAG_W-1:0] quot;
	} div_rsp_t;

	function automatic logic signed [14:0] lane_weight(input logic [2:0] lane);
		logic signed [14:0] w;
		unique case (lane)
			3'd1:    w = -15'sd2500;
			3'd2:    w = -15'sd1500;
			3'd3:    w = -15'sd500;
			3'd4:    w = 15'sd500;
			3'd5:    w = 15'sd1500;
			3'd6:    w = 15'sd2500;
			default: w = 15'sd0;
		endcase
		return w;
	endfunction

endpackage

/* rtl/core/lsfp_div.sv */
module lsfp_div
	import lsfp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [MAG_W-1:0] mag_q;
	logic [MAG_W-1:0] quo_q;
	logic [2:0]       rem_q;
	logic [2:0]       den_q;
	logic [3:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             neg_q;

	logic [3:0] trial;
	logic       ge;
	logic [3:0] diff;

	// one restoring step per cycle, MSB first
	assign trial = {rem_q, mag_q[MAG_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mag_q <= req.mag;
			den_q <= req.den;
			neg_q <= req.neg;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			mag_q <= {mag_q[MAG_W-2:0], 1'b0};
			rem_q <= ge ? diff[2:0] : trial[2:0];
			quo_q <= {quo_q[MAG_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = neg_q ? -$signed(quo_q) : $signed(quo_q);

	a_start_den: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> req.den != 3'd0)
		else $error("divider started with zero divisor");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !req.start)
		else $error("divider restarted while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a run");

endmodule

/* rtl/core/line_sensor_frame_parser.sv */
// One byte per input beat; every byte yields one result beat, and the input stays
// not ready until that result leaves. Most bytes: result valid the cycle after the
// input beat. Valid frame with detection: the divider runs its 13 restoring steps,
// then the quotient is registered into the published position as the state moves
// to output, and only then is the result valid.
// arst_n clears parser state, published values (lost flag set) and counters.
module line_sensor_frame_parser
	import lsfp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          rx_byte,
	input  logic [31:0]         now_ms,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          event_res,
	output logic [7:0]          channel_mask,
	output logic [6:0]          detect_bits,
	output logic [2:0]          active_count,
	output logic                line_lost,
	output logic signed [12:0]  position,
	output logic signed [12:0]  last_position,
	output logic [31:0]         last_detection_time,
	output logic [31:0]         valid_frames,
	output logic [31:0]         checksum_errors,
	output logic [31:0]         format_errors,
	output logic [31:0]         detection_events
);

	state_t     state_q;
	logic [3:0] fp_q;
	logic [7:0] chan_q;
	logic [7:0] sum_q;
	ev_t        ev_q;

	logic [7:0]         mask_q;
	logic [6:0]         det_q;
	logic [2:0]         cnt_q;
	logic               lost_q;
	logic signed [12:0] pos_q;
	logic signed [12:0] last_pos_q;
	logic [31:0]        last_time_q;
	logic [31:0]        time_hold_q;
	logic [31:0]        n_valid_q;
	logic [31:0]        n_csum_q;
	logic [31:0]        n_format_q;
	logic [31:0]        n_detect_q;

	logic       accept;
	logic [3:0] fp_d;
	logic [7:0] chan_d;
	logic [7:0] sum_d;
	ev_t        ev_d;
	logic [3:0] fp_m1;

	logic [6:0]         det_new;
	logic [2:0]         cnt_new;
	logic signed [14:0] wsum;
	logic [14:0]        wabs;

	div_req_t div_req;
	div_rsp_t div_rsp;

	assign accept = in_valid && in_ready;
	assign fp_m1  = fp_q - 4'd1;

	always_comb begin
		fp_d   = fp_q;
		chan_d = chan_q;
		sum_d  = sum_q;
		ev_d   = EV_NONE;
		priority if (fp_q == FP_IDLE) begin
			fp_d  = (rx_byte == HDR_BYTE) ? 4'd1 : FP_IDLE;
			sum_d = '0;
		end else if (fp_q <= FP_LAST_CH) begin
			if (rx_byte > 8'd1) begin
				ev_d  = EV_FORMAT;
				fp_d  = (rx_byte == HDR_BYTE) ? 4'd1 : FP_IDLE;
				sum_d = '0;
			end else begin
				chan_d[fp_m1[2:0]] = rx_byte[0];
				sum_d = sum_q + rx_byte;
				fp_d  = fp_q + 4'd1;
			end
		end else if (fp_q == FP_CSUM) begin
			if (rx_byte != sum_q) begin
				ev_d  = EV_CHECKSUM;
				fp_d  = (rx_byte == HDR_BYTE) ? 4'd1 : FP_IDLE;
				sum_d = '0;
			end else begin
				fp_d = FP_TAIL;
			end
		end else begin
			sum_d = '0;
			if (rx_byte != TAIL_BYTE) begin
				ev_d = EV_FORMAT;
				fp_d = (rx_byte == HDR_BYTE) ? 4'd1 : FP_IDLE;
			end else begin
				ev_d = EV_VALID;
				fp_d = FP_IDLE;
			end
		end
	end

	// active-low detect over channels 2..7 (bits 1..6)
	always_comb begin
		det_new = '0;
		cnt_new = '0;
		wsum    = '0;
		for (int i = 1; i <= 6; i++) begin
			if (!chan_q[i]) begin
				det_new[i] = 1'b1;
				cnt_new    = cnt_new + 3'd1;
				wsum       = wsum + lane_weight(3'(i));
			end
		end
	end

	assign wabs = wsum[14] ? 15'(-wsum) : 15'(wsum);

	assign div_req.start = accept && (ev_d == EV_VALID) && (cnt_new != 3'd0);
	assign div_req.neg   = wsum[14];
	assign div_req.mag   = wabs[MAG_W-1:0];
	assign div_req.den   = cnt_new;

	lsfp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fp_q        <= FP_IDLE;
			chan_q      <= '0;
			sum_q       <= '0;
			ev_q        <= EV_NONE;
			mask_q      <= '0;
			det_q       <= '0;
			cnt_q       <= '0;
			lost_q      <= 1'b1;
			pos_q       <= '0;
			last_pos_q  <= '0;
			last_time_q <= '0;
			n_valid_q   <= '0;
			n_csum_q    <= '0;
			n_format_q  <= '0;
			n_detect_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						fp_q   <= fp_d;
						chan_q <= chan_d;
						sum_q  <= sum_d;
						ev_q   <= ev_d;
						state_q <= div_req.start ? ST_DIV : ST_OUT;
						if (ev_d == EV_FORMAT) n_format_q <= n_format_q + 32'd1;
						if (ev_d == EV_CHECKSUM) n_csum_q <= n_csum_q + 32'd1;
						if (ev_d == EV_VALID) begin
							n_valid_q <= n_valid_q + 32'd1;
							mask_q    <= chan_q;
							det_q     <= det_new;
							cnt_q     <= cnt_new;
							lost_q    <= (cnt_new == 3'd0);
						end
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						pos_q       <= div_rsp.quot;
						last_pos_q  <= div_rsp.quot;
						last_time_q <= time_hold_q;
						n_detect_q  <= n_detect_q + 32'd1;
						state_q     <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (div_req.start) time_hold_q <= now_ms;
	end

	assign in_ready            = (state_q == ST_IDLE);
	assign out_valid           = (state_q == ST_OUT);
	assign event_res           = ev_q;
	assign channel_mask        = mask_q;
	assign detect_bits         = det_q;
	assign active_count        = cnt_q;
	assign line_lost           = lost_q;
	assign position            = pos_q;
	assign last_position       = last_pos_q;
	assign last_detection_time = last_time_q;
	assign valid_frames        = n_valid_q;
	assign checksum_errors     = n_csum_q;
	assign format_errors       = n_format_q;
	assign detection_events    = n_detect_q;

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a result is pending");
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("divider result outside divide state");
	a_count_mask: assert property (@(posedge clk) disable iff (!arst_n)
		($countones(det_q) == int'(cnt_q)) && (lost_q == (cnt_q == 3'd0)) && !det_q[0])
		else $error("published count, mask and lost flag disagree");
	a_fp_range: assert property (@(posedge clk) disable iff (!arst_n)
		fp_q <= FP_TAIL)
		else $error("frame position out of range");
	a_div_then_detect: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) && div_rsp.done |=> n_detect_q == $past(n_detect_q) + 32'd1)
		else $error("detect counter missed a detection");

endmodule
